>>> hw/rtl/gdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, constants and calendar tables for the Gregorian day-distance
// pipeline.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIST_W  = 22;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned Q100_W  = 8;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for every 14-bit p.
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_t;

  // Stage advance strobes shared by every pipeline section.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gdd_day_number.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_day_number
// Three-stage pipeline that checks one date and turns it into a day number
// counted from 1 January of year 1.
// ----------------------------------------------------------------------------
module gdd_day_number import gdd_pkg::*; (
  input  wire logic               clk,
  input  wire adv_t               adv,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  output logic                    date_ok,
  output logic [DIST_W-1:0]       day_num
);

  localparam int unsigned PROD_W = YEAR_W + 13;

  // Stage 1: range checks, year offset and its quotient by 100.
  logic [DAY_W-1:0]   s1_day;
  logic [MONTH_W-1:0] s1_month;
  logic [YEAR_W-1:0]  s1_p;
  logic [Q100_W-1:0]  s1_q;
  logic               s1_range_ok;

  logic [YEAR_W-1:0]  p_in;
  logic [PROD_W-1:0]  prod;

  assign p_in = year - YEAR_W'(1);
  assign prod = PROD_W'(p_in) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_day      <= day;
      s1_month    <= month;
      s1_p        <= p_in;
      s1_q        <= prod[RECIP_SHIFT +: Q100_W];
      s1_range_ok <= (year != '0) && (year <= YEAR_MAX) &&
                     (month != '0) && (month <= MONTH_W'(12));
    end
  end

  // Stage 2: leap year, day check, year base and day of year.
  // The year is a multiple of 100 exactly when p mod 100 is 99, and a
  // multiple of 400 when additionally floor(p / 100) mod 4 is 3.
  logic [YEAR_W-1:0] rem100;
  logic              century;
  logic              leap;
  logic [DAY_W-1:0]  len;
  logic              day_ok;
  logic [DIST_W-1:0] base;
  logic [DOY_W-1:0]  doy;

  always_comb begin
    rem100  = s1_p - YEAR_W'(s1_q) * YEAR_W'(100);
    century = (rem100 == YEAR_W'(99));
    leap    = ((s1_p[1:0] == 2'd3) && !century) ||
              (century && (s1_q[1:0] == 2'd3));
    len     = month_len(s1_month);
    if ((s1_month == MONTH_W'(2)) && leap) begin
      len = DAY_W'(29);
    end
    day_ok  = (s1_day != '0) && (s1_day <= len);
    base    = DIST_W'(s1_p) * DIST_W'(365) + DIST_W'(s1_p >> 2)
              - DIST_W'(s1_q) + DIST_W'(s1_q >> 2);
    doy     = days_before(s1_month) + DOY_W'(s1_day) +
              DOY_W'((s1_month > MONTH_W'(2)) && leap);
  end

  logic              s2_ok;
  logic [DIST_W-1:0] s2_base;
  logic [DOY_W-1:0]  s2_doy;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_ok   <= s1_range_ok && day_ok;
      s2_base <= base;
      s2_doy  <= doy;
    end
  end

  // Stage 3: final day number.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      date_ok <= s2_ok;
      day_num <= s2_base + DIST_W'(s2_doy);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gregorian_date_difference.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Checks two proleptic Gregorian dates and reports the absolute number of
// days between them, or which date is invalid.
// ----------------------------------------------------------------------------
//
//   channel | handshake                   | payload
//   --------+-----------------------------+---------------------------------
//   input   | in_valid / in_ready         | first_/second_ day, month, year
//   output  | out_valid / out_ready       | status, day_distance
//
// Every transaction passes four register stages, and a transaction can enter
// every cycle while the output does not stall.
// Stages: year quotient by 100 (reciprocal multiply), leap check and year base,
// day numbers, then status and absolute difference.
// A stage loads when it is empty or the next stage moves, so an output stall
// backs up stage by stage. Reset empties all stages; no data register is cleared.
// ----------------------------------------------------------------------------
module gregorian_date_difference import gdd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [DAY_W-1:0]   first_day,
  input  wire logic [MONTH_W-1:0] first_month,
  input  wire logic [YEAR_W-1:0]  first_year,
  input  wire logic [DAY_W-1:0]   second_day,
  input  wire logic [MONTH_W-1:0] second_month,
  input  wire logic [YEAR_W-1:0]  second_year,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [DIST_W-1:0]       day_distance
);

  // Occupancy of each stage; stage four is the output register.
  logic v1, v2, v3, v4;
  logic adv4;
  adv_t adv;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    adv4   = !v4 || out_ready;
    adv.s3 = !v3 || adv4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv4)   v4 <= v3;
    end
  end

  // Both dates run through identical day-number pipelines in lockstep.
  logic              ok_a, ok_b;
  logic [DIST_W-1:0] num_a, num_b;

  gdd_day_number u_first (
    .clk     (clk),
    .adv     (adv),
    .day     (first_day),
    .month   (first_month),
    .year    (first_year),
    .date_ok (ok_a),
    .day_num (num_a)
  );

  gdd_day_number u_second (
    .clk     (clk),
    .adv     (adv),
    .day     (second_day),
    .month   (second_month),
    .year    (second_year),
    .date_ok (ok_b),
    .day_num (num_b)
  );

  // Stage four: the first date is judged before the second, and an invalid
  // date forces the distance to zero. Both differences are formed and the
  // one without a borrow is kept.
  status_t           status_next;
  logic [DIST_W:0]   diff_ab;
  logic [DIST_W-1:0] diff_ba;
  logic [DIST_W-1:0] dist_next;

  always_comb begin
    diff_ab = {1'b0, num_a} - {1'b0, num_b};
    diff_ba = num_b - num_a;
    priority if (!ok_a) begin
      status_next = STATUS_FIRST_BAD;
      dist_next   = '0;
    end else if (!ok_b) begin
      status_next = STATUS_SECOND_BAD;
      dist_next   = '0;
    end else begin
      status_next = STATUS_OK;
      dist_next   = diff_ab[DIST_W] ? diff_ba : diff_ab[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      status       <= status_next;
      day_distance <= dist_next;
    end
  end

  assign out_valid = v4;

  // An error result never carries a distance.
  a_err_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (day_distance == '0))
    else $error("error status with nonzero day_distance");

  // Only the three defined status codes ever leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == STATUS_OK) || (status == STATUS_FIRST_BAD) ||
                   (status == STATUS_SECOND_BAD)))
    else $error("undefined status code");

  // Input is refused only when every stage is full and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4 && !out_ready))
    else $error("pipeline refused input with room left");

  // A result taken with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !v3) |=> !out_valid)
    else $error("result repeated after handshake");

endmodule
`default_nettype wire
